@@ rtl/core/dwct_pkg.sv @@
// Shared constants, types and window arithmetic for the dual-window centroid tracker.
package dwct_pkg;

    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;

    localparam int COORD_W    = 10;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 11;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 30;
    localparam int POINT_W    = 12;
    localparam int CENTER_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(64);
    localparam logic [CNT_W-1:0]  MIN_RST   = CNT_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_START,
        REG_LOW_START,
        REG_UP_WIDTH,
        REG_UP_HEIGHT,
        REG_LOW_WIDTH,
        REG_LOW_HEIGHT,
        REG_MIN_PIXELS
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_UP_X,
        OP_UP_Y,
        OP_LOW_X,
        OP_LOW_Y
    } div_op_t;

    // half-open box test on one axis: pos <= coord < pos + size
    function automatic logic in_span(logic [POS_W-1:0] pos, logic [SIZE_W-1:0] size,
                                     logic [COORD_W-1:0] coord);
        logic signed [CENTER_W-1:0] lo;
        logic signed [CENTER_W-1:0] hi;
        logic signed [CENTER_W-1:0] c;
        lo = $signed({{(CENTER_W-POS_W){pos[POS_W-1]}}, pos});
        hi = lo + $signed({{(CENTER_W-SIZE_W){1'b0}}, size});
        c  = $signed({{(CENTER_W-COORD_W){1'b0}}, coord});
        return (c >= lo) && (c < hi);
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] cnt);
        return (cnt == COUNT_MAX) ? cnt : cnt + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] sum,
                                                 logic [COORD_W-1:0] coord);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + {{(SUM_W+1-COORD_W){1'b0}}, coord};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // frame point: mean when found, else window centre
    function automatic logic [POINT_W-1:0] frame_point(logic found, logic [COORD_W-1:0] mean,
                                                        logic [POS_W-1:0] pos,
                                                        logic [SIZE_W-1:0] size);
        logic [COORD_W-1:0] half;
        half = size[SIZE_W-1:1];
        if (found)
            return {{(POINT_W-COORD_W){1'b0}}, mean};
        return {pos[POS_W-1], pos} + {{(POINT_W-COORD_W){1'b0}}, half};
    endfunction

    // recentred corner; unchanged when the centre was used
    function automatic logic [POS_W-1:0] new_corner(logic found, logic [COORD_W-1:0] mean,
                                                     logic [POS_W-1:0] pos,
                                                     logic [SIZE_W-1:0] size);
        logic [COORD_W-1:0] half;
        logic [POINT_W-1:0] d;
        half = size[SIZE_W-1:1];
        d = {{(POINT_W-COORD_W){1'b0}}, mean} - {{(POINT_W-COORD_W){1'b0}}, half};
        return found ? d[POS_W-1:0] : pos;
    endfunction

endpackage

@@ rtl/core/dual_window_centroid_tracker_core.sv @@
// Dual-window centroid tracker: per-pixel accumulation and a shared serial divider.
//
//  channel | signals                               | word
//  --------+---------------------------------------+--------------------------------------
//  pixels  | s_tvalid s_tready s_tdata s_tlast     | value, x, y; tlast = end of frame
//  result  | m_tvalid m_tready m_tdata m_tuser     | centres, corners; tuser = found flags
//  config  | cfg_we cfg_addr cfg_data              | register write, no read-back
//
// A pixel word without tlast only updates the sums and counts. A tlast word starts four
// divisions on one shared restore divider (1 load + 30 steps each); the block stays
// busy through them and through any wait for the result register to empty.
// Reset is asynchronous, active low; windows come out at the start registers' reset.
// A stalled result holds in the output register; the next frame's pixels are
// taken while it waits.
module dual_window_centroid_tracker_core
    import dwct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // pixel_value[7:0], pixel_x[17:8], pixel_y[27:18]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // center_x2, center_y2, up_pos_x, up_pos_y,
                                              // low_pos_x, low_pos_y
    output logic [M_TUSER_W-1:0]   m_tuser,   // up_found, low_found
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    div_op_t             op_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    work_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [COORD_W-1:0]  quot_reg [4];

    logic [POS_W-1:0]    up_x_reg, up_y_reg, low_x_reg, low_y_reg;
    logic [SIZE_W-1:0]   up_w_reg, up_h_reg, low_w_reg, low_h_reg;
    logic [CNT_W-1:0]    min_pixels_reg;
    logic [CNT_W-1:0]    up_cnt_reg, low_cnt_reg;
    logic [SUM_W-1:0]    up_sx_reg, up_sy_reg, low_sx_reg, low_sy_reg;

    logic                    m_tvalid_reg;
    logic [CENTER_W-1:0]     cx2_reg, cy2_reg;
    logic [POS_W-1:0]        out_ux_reg, out_uy_reg, out_lx_reg, out_ly_reg;
    logic                    out_uf_reg, out_lf_reg;

    logic [7:0]          pix_value;
    logic [COORD_W-1:0]  pix_x, pix_y;
    logic                accept, pix_set, up_hit, low_hit;

    logic [SUM_W-1:0]    dividend_sel;
    logic [CNT_W-1:0]    divisor_sel;
    logic [CNT_W:0]      rem_shift, rem_diff;
    logic                q_bit;
    logic [SUM_W-1:0]    work_next;
    logic [CNT_W-1:0]    rem_next;

    logic                up_found, low_found;
    logic [POINT_W-1:0]  pt_ux, pt_uy, pt_lx, pt_ly;
    logic [CENTER_W-1:0] cx2_next, cy2_next;
    logic [POS_W-1:0]    ux_next, uy_next, lx_next, ly_next;

    assign pix_value = s_tdata[7:0];
    assign pix_x     = s_tdata[17:8];
    assign pix_y     = s_tdata[27:18];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign pix_set = (pix_value != 8'd0) && (32'(pix_x) < IMAGE_WIDTH)
                     && (32'(pix_y) < IMAGE_HEIGHT);
    assign up_hit  = pix_set && in_span(up_x_reg, up_w_reg, pix_x)
                     && in_span(up_y_reg, up_h_reg, pix_y);
    assign low_hit = pix_set && in_span(low_x_reg, low_w_reg, pix_x)
                     && in_span(low_y_reg, low_h_reg, pix_y);

    // shared restoring divider: sum / count, one quotient bit a cycle
    always_comb
    begin
        case (op_reg)
            OP_UP_X:  dividend_sel = up_sx_reg;
            OP_UP_Y:  dividend_sel = up_sy_reg;
            OP_LOW_X: dividend_sel = low_sx_reg;
            default:  dividend_sel = low_sy_reg;
        endcase
        divisor_sel = ((op_reg == OP_UP_X) || (op_reg == OP_UP_Y)) ? up_cnt_reg : low_cnt_reg;
        rem_shift   = {rem_reg, work_reg[SUM_W-1]};
        rem_diff    = rem_shift - {1'b0, divisor_sel};
        q_bit       = (rem_shift >= {1'b0, divisor_sel});
        work_next   = {work_reg[SUM_W-2:0], q_bit};
        rem_next    = q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end

    always_comb
    begin
        up_found  = (up_cnt_reg > min_pixels_reg);
        low_found = (low_cnt_reg > min_pixels_reg);
        pt_ux = frame_point(up_found, quot_reg[OP_UP_X], up_x_reg, up_w_reg);
        pt_uy = frame_point(up_found, quot_reg[OP_UP_Y], up_y_reg, up_h_reg);
        pt_lx = frame_point(low_found, quot_reg[OP_LOW_X], low_x_reg, low_w_reg);
        pt_ly = frame_point(low_found, quot_reg[OP_LOW_Y], low_y_reg, low_h_reg);
        cx2_next = {pt_ux[POINT_W-1], pt_ux} + {pt_lx[POINT_W-1], pt_lx};
        cy2_next = {pt_uy[POINT_W-1], pt_uy} + {pt_ly[POINT_W-1], pt_ly};
        ux_next = new_corner(up_found, quot_reg[OP_UP_X], up_x_reg, up_w_reg);
        uy_next = new_corner(up_found, quot_reg[OP_UP_Y], up_y_reg, up_h_reg);
        lx_next = new_corner(low_found, quot_reg[OP_LOW_X], low_x_reg, low_w_reg);
        ly_next = new_corner(low_found, quot_reg[OP_LOW_Y], low_y_reg, low_h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_UP_X;
            step_reg       <= '0;
            work_reg       <= '0;
            rem_reg        <= '0;
            for (int i = 0; i < 4; i++)
                quot_reg[i] <= '0;
            up_x_reg       <= '0;
            up_y_reg       <= '0;
            low_x_reg      <= '0;
            low_y_reg      <= '0;
            up_w_reg       <= SIZE_RST;
            up_h_reg       <= SIZE_RST;
            low_w_reg      <= SIZE_RST;
            low_h_reg      <= SIZE_RST;
            min_pixels_reg <= MIN_RST;
            up_cnt_reg     <= '0;
            low_cnt_reg    <= '0;
            up_sx_reg      <= '0;
            up_sy_reg      <= '0;
            low_sx_reg     <= '0;
            low_sy_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            cx2_reg        <= '0;
            cy2_reg        <= '0;
            out_ux_reg     <= '0;
            out_uy_reg     <= '0;
            out_lx_reg     <= '0;
            out_ly_reg     <= '0;
            out_uf_reg     <= 1'b0;
            out_lf_reg     <= 1'b0;
        end
        else
        begin
            // ST_FINISH drives the valid flag itself
            if (m_tready && (state_reg != ST_FINISH))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (up_hit)
                        begin
                            up_cnt_reg <= sat_count(up_cnt_reg);
                            up_sx_reg  <= sat_sum(up_sx_reg, pix_x);
                            up_sy_reg  <= sat_sum(up_sy_reg, pix_y);
                        end
                        if (low_hit)
                        begin
                            low_cnt_reg <= sat_count(low_cnt_reg);
                            low_sx_reg  <= sat_sum(low_sx_reg, pix_x);
                            low_sy_reg  <= sat_sum(low_sy_reg, pix_y);
                        end
                        if (s_tlast)
                        begin
                            op_reg    <= OP_UP_X;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    work_reg  <= dividend_sel;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    work_reg <= work_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        quot_reg[op_reg] <= work_next[COORD_W-1:0];
                        if (op_reg == OP_LOW_Y)
                            state_reg <= ST_FINISH;
                        else
                        begin
                            op_reg    <= div_op_t'(op_reg + 2'd1);
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_FINISH:
                begin
                    // wait for the result register to be free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        cx2_reg      <= cx2_next;
                        cy2_reg      <= cy2_next;
                        out_ux_reg   <= ux_next;
                        out_uy_reg   <= uy_next;
                        out_lx_reg   <= lx_next;
                        out_ly_reg   <= ly_next;
                        out_uf_reg   <= up_found;
                        out_lf_reg   <= low_found;
                        up_x_reg     <= ux_next;
                        up_y_reg     <= uy_next;
                        low_x_reg    <= lx_next;
                        low_y_reg    <= ly_next;
                        up_cnt_reg   <= '0;
                        low_cnt_reg  <= '0;
                        up_sx_reg    <= '0;
                        up_sy_reg    <= '0;
                        low_sx_reg   <= '0;
                        low_sy_reg   <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_UP_START:
                    begin
                        up_x_reg <= {1'b0, cfg_data[9:0]};
                        up_y_reg <= {1'b0, cfg_data[19:10]};
                    end
                    REG_LOW_START:
                    begin
                        low_x_reg <= {1'b0, cfg_data[9:0]};
                        low_y_reg <= {1'b0, cfg_data[19:10]};
                    end
                    REG_UP_WIDTH:   up_w_reg       <= cfg_data[SIZE_W-1:0];
                    REG_UP_HEIGHT:  up_h_reg       <= cfg_data[SIZE_W-1:0];
                    REG_LOW_WIDTH:  low_w_reg      <= cfg_data[SIZE_W-1:0];
                    REG_LOW_HEIGHT: low_h_reg      <= cfg_data[SIZE_W-1:0];
                    REG_MIN_PIXELS: min_pixels_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_ly_reg, out_lx_reg, out_uy_reg, out_ux_reg, cy2_reg, cx2_reg};
    assign m_tuser  = {out_lf_reg, out_uf_reg};

endmodule

@@ rtl/core/dwct_checker.sv @@
// Port-level checks for the dual-window centroid tracker, bound to the core.
module dwct_checker
    import dwct_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    // end-of-frame word starts the divider, so input side goes busy
    a_busy_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after end-of-frame word");

    // a result only shows up at the end of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word without a preceding end-of-frame");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

    // no plain pixel word ever makes a result
    a_no_result_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast && !m_tvalid) |=> !m_tvalid)
        else $error("result word after a plain pixel");

endmodule

bind dual_window_centroid_tracker_core dwct_checker u_dwct_checker (.*);
